@@ rtl/core/crcfr_pkg.sv @@
// crcfr_pkg: shared types, constants and the crc-8 byte update for the frame receiver
// no dependencies
`timescale 1ns / 1ps

package crcfr_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned VALUE_W  = 16;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned POS_W    = 3;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [BYTE_W-1:0] HEADER_BYTE   = 8'h09;
	localparam logic [BYTE_W-1:0] CRC_INIT      = 8'hFF;
	localparam logic [BYTE_W-1:0] CRC_POLY      = 8'h31;
	localparam logic [BYTE_W-1:0] TRAILER_FIRST = 8'h01;
	localparam logic [BYTE_W-1:0] TRAILER_LAST  = 8'h23;

	localparam logic [BYTE_W-1:0] DATA_TYPE_RESET    = 8'h00;
	localparam logic [BYTE_W-1:0] COMMAND_TYPE_RESET = 8'h01;

	localparam logic [CFG_IDX_W-1:0] REG_DATA_TYPE    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_COMMAND_TYPE = 1'b1;

	// frame byte positions, hunt means waiting for the header
	typedef enum logic [POS_W-1:0] {
		POS_HUNT     = 3'd0,
		POS_TYPE     = 3'd1,
		POS_VALUE_HI = 3'd2,
		POS_VALUE_LO = 3'd3,
		POS_CRC      = 3'd4,
		POS_TRAIL_0  = 3'd5,
		POS_TRAIL_1  = 3'd6
	} pos_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_SPEED   = 3'd0,
		ST_COMMAND = 3'd1,
		ST_UNKNOWN = 3'd2,
		ST_CRC     = 3'd3,
		ST_TRAILER = 3'd4
	} status_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data_type_code;
		logic [BYTE_W-1:0] command_type_code;
	} cfg_t;

	typedef struct packed {
		status_t             frame_status;
		logic [VALUE_W-1:0]  frame_value;
	} result_t;

	// msb first, no reflection, no final xor
	function automatic logic [BYTE_W-1:0] crc_feed(input logic [BYTE_W-1:0] crc,
			input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] c;
		c = crc ^ b;
		for (int i = 0; i < BYTE_W; i++) begin
			if (c[BYTE_W-1]) begin
				c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[BYTE_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

@@ rtl/core/crcfr_cfg.sv @@
// crcfr_cfg: type code registers written through the configuration port
// depends on crcfr_pkg
`timescale 1ns / 1ps

module crcfr_cfg import crcfr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data,
	output cfg_t                 cfg
);

	logic [BYTE_W-1:0] data_type_code_q;
	logic [BYTE_W-1:0] command_type_code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_type_code_q    <= DATA_TYPE_RESET;
			command_type_code_q <= COMMAND_TYPE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DATA_TYPE:    data_type_code_q    <= cfg_data;
				REG_COMMAND_TYPE: command_type_code_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg.data_type_code    = data_type_code_q;
	assign cfg.command_type_code = command_type_code_q;

endmodule

@@ rtl/core/crcfr_parser.sv @@
// crcfr_parser: header hunt, frame collection, crc and trailer checks
// depends on crcfr_pkg; produces one result per completed frame
`timescale 1ns / 1ps

module crcfr_parser import crcfr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [BYTE_W-1:0] rx_byte,
	input  logic              res_ready,
	output logic              res_valid,
	output result_t           res
);

	pos_t               pos_q;
	logic [BYTE_W-1:0]  crc_q;
	logic [BYTE_W-1:0]  kind_q;
	logic [VALUE_W-1:0] value_q;
	logic               check_failed_q;
	logic               trailer_failed_q;

	logic               accept;
	logic [BYTE_W-1:0]  crc_next;
	logic               trailer_bad;

	// only the last frame byte needs room downstream
	assign in_stall = (pos_q == POS_TRAIL_1) && !res_ready;
	assign accept   = in_valid && !in_stall;

	assign crc_next    = crc_feed((pos_q == POS_HUNT) ? CRC_INIT : crc_q, rx_byte);
	assign trailer_bad = trailer_failed_q || (rx_byte != TRAILER_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q            <= POS_HUNT;
			crc_q            <= CRC_INIT;
			kind_q           <= '0;
			value_q          <= '0;
			check_failed_q   <= 1'b0;
			trailer_failed_q <= 1'b0;
		end else if (accept) begin
			case (pos_q)
				POS_TYPE: begin
					kind_q <= rx_byte;
					crc_q  <= crc_next;
					pos_q  <= POS_VALUE_HI;
				end
				POS_VALUE_HI: begin
					value_q <= {rx_byte, {BYTE_W{1'b0}}};
					crc_q   <= crc_next;
					pos_q   <= POS_VALUE_LO;
				end
				POS_VALUE_LO: begin
					value_q[BYTE_W-1:0] <= rx_byte;
					crc_q <= crc_next;
					pos_q <= POS_CRC;
				end
				POS_CRC: begin
					check_failed_q <= (rx_byte != crc_q);
					pos_q          <= POS_TRAIL_0;
				end
				POS_TRAIL_0: begin
					trailer_failed_q <= (rx_byte != TRAILER_FIRST);
					pos_q            <= POS_TRAIL_1;
				end
				POS_TRAIL_1: begin
					pos_q            <= POS_HUNT;
					crc_q            <= CRC_INIT;
					check_failed_q   <= 1'b0;
					trailer_failed_q <= 1'b0;
				end
				default: begin
					if (rx_byte == HEADER_BYTE) begin
						crc_q            <= crc_next;
						check_failed_q   <= 1'b0;
						trailer_failed_q <= 1'b0;
						pos_q            <= POS_TYPE;
					end else begin
						pos_q <= POS_HUNT;
					end
				end
			endcase
		end
	end

	assign res_valid = accept && (pos_q == POS_TRAIL_1);

	always_comb begin
		res.frame_value = value_q;
		if (check_failed_q) begin
			res.frame_status = ST_CRC;
		end else if (trailer_bad) begin
			res.frame_status = ST_TRAILER;
		end else if (kind_q == cfg.data_type_code) begin
			res.frame_status = ST_SPEED;
		end else if (kind_q == cfg.command_type_code) begin
			res.frame_status = ST_COMMAND;
		end else begin
			res.frame_status = ST_UNKNOWN;
		end
	end

endmodule

@@ rtl/core/crcfr_out_reg.sv @@
// crcfr_out_reg: result register on the output channel
// depends on crcfr_pkg
`timescale 1ns / 1ps

module crcfr_out_reg import crcfr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                res_valid,
	input  result_t             res,
	output logic                res_ready,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STATUS_W-1:0] frame_status,
	output logic [VALUE_W-1:0]  frame_value
);

	logic    valid_q;
	result_t res_q;

	assign res_ready = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid    = valid_q;
	assign frame_status = res_q.frame_status;
	assign frame_value  = res_q.frame_value;

endmodule

@@ rtl/core/crc8_checked_frame_receiver.sv @@
// crc8_checked_frame_receiver: top level of the crc-8 checked frame receiver
// depends on crcfr_pkg, crcfr_cfg, crcfr_parser, crcfr_out_reg
//
// Input channel: one received byte per transaction (in_valid, in_stall, rx_byte).
// Bytes are dropped until the header 0x09 is seen, then a seven-byte frame is
// collected: header, type, value high, value low, crc, 0x01, 0x23.
// Output channel: one transaction per frame (out_valid, out_stall, frame_status,
// frame_value); status 0 speed, 1 command, 2 unknown type, 3 crc, 4 trailer.
// Throughput: one byte every cycle while in_stall is low; the crc update runs on the header, type and value bytes.
// Latency: the result is valid in the cycle after the seventh frame byte.
// When the receiver stalls, the result waits in the output register and bytes
// keep being accepted; only a seventh frame byte is held off while it is full.
// Configuration: cfg_we with cfg_index 0 writes the data type code, index 1
// the command type code; write only while no frame is in progress.
// Reset: hunting for a header, type codes 0 and 1, output empty.
`timescale 1ns / 1ps

module crc8_checked_frame_receiver import crcfr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [BYTE_W-1:0]    rx_byte,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [STATUS_W-1:0]  frame_status,
	output logic [VALUE_W-1:0]   frame_value,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data
);

	cfg_t    cfg;
	logic    res_valid;
	logic    res_ready;
	result_t res;

	crcfr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	crcfr_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.rx_byte   (rx_byte),
		.res_ready (res_ready),
		.res_valid (res_valid),
		.res       (res)
	);

	crcfr_out_reg u_out_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.res_valid    (res_valid),
		.res          (res),
		.res_ready    (res_ready),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.frame_status (frame_status),
		.frame_value  (frame_value)
	);

endmodule
